// ===== rtl/core/cig_pkg.sv =====
// Package for the consecutive integer GCD block.
// Holds the sequencer state type and the remainder unit status struct.
// No dependencies.
package cig_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_DONE
   } cig_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cig_rem_status_type;

endpackage : cig_pkg

// ===== rtl/core/cig_rem_unit.sv =====
// Two-lane restoring remainder unit: one bit of both remainders per cycle.
// Depends on cig_pkg for the status struct.
module cig_rem_unit
   import cig_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WIDTH-1:0]   dividend_a,
   input  logic [WIDTH-1:0]   dividend_b,
   input  logic [WIDTH-1:0]   divisor,
   output cig_rem_status_type status,
   output logic [WIDTH-1:0]   rem_a,
   output logic [WIDTH-1:0]   rem_b
);

   localparam int CNT_BITS = $clog2(WIDTH);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(WIDTH - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0]    qa_ff, qa_in, qb_ff, qb_in;
   logic [WIDTH-1:0]    ra_ff, ra_in, rb_ff, rb_in;
   logic [WIDTH-1:0]    d_ff, d_in;
   logic [WIDTH:0]      sa, sb, da, db;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      qa_in   = qa_ff;
      qb_in   = qb_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      d_in    = d_ff;
      // Bring down the next dividend bit, then subtract the divisor if it fits.
      sa      = {ra_ff, qa_ff[WIDTH-1]};
      sb      = {rb_ff, qb_ff[WIDTH-1]};
      da      = sa - {1'b0, d_ff};
      db      = sb - {1'b0, d_ff};
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = LAST_STEP;
         qa_in   = dividend_a;
         qb_in   = dividend_b;
         ra_in   = '0;
         rb_in   = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         ra_in = (sa >= {1'b0, d_ff}) ? da[WIDTH-1:0] : sa[WIDTH-1:0];
         rb_in = (sb >= {1'b0, d_ff}) ? db[WIDTH-1:0] : sb[WIDTH-1:0];
         qa_in = {qa_ff[WIDTH-2:0], 1'b0};
         qb_in = {qb_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      qa_ff <= qa_in;
      qb_ff <= qb_in;
      ra_ff <= ra_in;
      rb_ff <= rb_in;
      d_ff  <= d_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign rem_a       = ra_ff;
   assign rem_b       = rb_ff;

   a_done_not_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("remainder unit signals done while still busy");

   a_done_pulse : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("remainder unit done lasted more than one cycle");

   a_rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      (done_ff && d_ff != '0) |-> (ra_ff < d_ff && rb_ff < d_ff))
      else $error("remainder not below divisor");

endmodule : cig_rem_unit

// ===== rtl/core/consecutive_integer_gcd_top.sv =====
// GCD by consecutive integer checking. Trial divisors count down from
// min(a,b), trials = min(a,b) - gcd + 1; an operand of zero skips the trials.
// A new word is not taken until the last one has been handed to the result
// register. Each trial runs the bit-serial remainder unit on both operands.
// A new word is taken only in the idle state, also while a result still waits.
// Synchronous active-high reset clears the sequencer and the result valid flag.
// Depends on cig_pkg and cig_rem_unit.
module consecutive_integer_gcd_top
   import cig_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: a_value, b_value, zero fill.
   input  logic [((2*WIDTH+7)/8)*8-1:0]        req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: divisor, check_count, zero fill.
   output logic [((2*WIDTH+7)/8)*8-1:0]        rsp_tdata
);

   localparam int BUS_BITS = ((2*WIDTH+7)/8)*8;
   localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

   cig_state_type      state_ff, state_in;
   logic [WIDTH-1:0]   a_ff, a_in, b_ff, b_in;
   logic [WIDTH-1:0]   trial_ff, trial_in;
   logic [WIDTH-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]   rsp_div_ff, rsp_div_in;
   logic [WIDTH-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic [WIDTH-1:0]   req_a, req_b;
   logic               rem_start;
   cig_rem_status_type rem_status;
   logic [WIDTH-1:0]   rem_a, rem_b;

   assign req_a = req_tdata[WIDTH-1:0];
   assign req_b = req_tdata[2*WIDTH-1:WIDTH];

   cig_rem_unit #(
      .WIDTH(WIDTH)
   ) u_rem (
      .clock      (clock),
      .reset      (reset),
      .start      (rem_start),
      .dividend_a (a_ff),
      .dividend_b (b_ff),
      .divisor    (trial_ff),
      .status     (rem_status),
      .rem_a      (rem_a),
      .rem_b      (rem_b)
   );

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      trial_in     = trial_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_div_in   = rsp_div_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      req_tready   = 1'b0;
      rem_start    = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               a_in = req_a;
               b_in = req_b;
               if (req_a == '0 || req_b == '0) begin
                  trial_in = ONE;
                  count_in = '0;
                  state_in = ST_DONE;
               end else begin
                  trial_in = (req_a < req_b) ? req_a : req_b;
                  count_in = ONE;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            rem_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (rem_status.done) begin
               // A trial of one always divides, so the countdown ends there.
               if (rem_a == '0 && rem_b == '0) begin
                  state_in = ST_DONE;
               end else begin
                  trial_in = trial_ff - ONE;
                  count_in = count_ff + ONE;
                  state_in = ST_START;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_div_in   = trial_ff;
               rsp_cnt_in   = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff       <= a_in;
      b_ff       <= b_in;
      trial_ff   <= trial_in;
      count_ff   <= count_in;
      rsp_div_ff <= rsp_div_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = BUS_BITS'({rsp_cnt_ff, rsp_div_ff});

   a_unit_idle_outside_trial : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> !rem_status.busy)
      else $error("remainder unit busy outside a trial");

   a_trial_nonzero : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START || state_ff == ST_WAIT) |-> trial_ff != '0)
      else $error("trial divisor reached zero");

   a_done_only_waiting : assert property (@(posedge clock) disable iff (reset)
      rem_status.done |-> state_ff == ST_WAIT)
      else $error("remainder result arrived outside the wait state");

endmodule : consecutive_integer_gcd_top
